// ===== rtl/core/lars_pkg.sv =====
// ----------------------------------------------------------------------------
// LARS momentum update package
// Shared widths, register indexes and the front-to-back command type.
// ----------------------------------------------------------------------------
package lars_pkg;

    // A tensor length that the 48-bit sums hold without saturating.
    localparam int MAX_ELEMENTS = 65536;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 24;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_BASE_RATE = 3'd0,
        CFG_MOMENTUM  = 3'd1,
        CFG_TRUST     = 3'd2,
        CFG_DECAY     = 3'd3,
        CFG_MASK_EN   = 3'd4
    } cfg_idx_t;

    // Command handed from the front part to the back part.
    typedef struct packed {
        logic              is_update;
        logic signed [15:0] gradient;
        logic signed [15:0] history;
        logic signed [15:0] mask;
        logic              last;
    } lars_cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_UPD_MUL,
        BK_UPD_MASK,
        BK_SQRT,
        BK_DIV,
        BK_RATE,
        BK_OUT
    } bk_state_t;

endpackage

// ===== rtl/core/lars_front.sv =====
// ----------------------------------------------------------------------------
// LARS front part
// Accepts elements, accumulates the squared norms and queues commands.
// ----------------------------------------------------------------------------
module lars_front
    import lars_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             mode,
    input  logic signed [15:0] weight,
    input  logic signed [15:0] gradient,
    input  logic signed [15:0] history,
    input  logic signed [15:0] mask,
    input  logic             last,
    // Snapshot of the sums on a norm-pass end.
    output logic [47:0]      wsum_snap,
    output logic [47:0]      gsum_snap,
    output logic             q_valid,
    output lars_cmd_t        q_cmd,
    input  logic             q_pop
);

    localparam int QDepth = 2;

    logic [47:0] wsum_reg, gsum_reg, wsum_next, gsum_next;
    lars_cmd_t   q_reg [QDepth];
    logic [47:0] qw_reg [QDepth], qg_reg [QDepth];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        take;
    logic [31:0] wsq, gsq;
    logic [48:0] ws, gs;
    lars_cmd_t   cmd;

    // Stall when the command queue is full.
    assign in_stall = (cnt_reg == 2'(QDepth));
    assign take = in_valid && !in_stall;

    // Square and accumulate with saturation.
    always_comb
    begin
        wsq = 32'(weight) * 32'(weight);
        gsq = 32'(gradient) * 32'(gradient);
        ws = {1'b0, wsum_reg} + 49'(wsq);
        gs = {1'b0, gsum_reg} + 49'(gsq);
        wsum_next = ws[48] ? '1 : ws[47:0];
        gsum_next = gs[48] ? '1 : gs[47:0];
        cmd.is_update = mode;
        cmd.gradient = gradient;
        cmd.history = history;
        cmd.mask = mask;
        cmd.last = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsum_reg <= '0;
            gsum_reg <= '0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (take && !mode)
            begin
                if (last)
                begin
                    wsum_reg <= '0;
                    gsum_reg <= '0;
                end
                else
                begin
                    wsum_reg <= wsum_next;
                    gsum_reg <= gsum_next;
                end
            end
            if (take && (mode || last))
                wp_reg <= ~wp_reg;
            if (q_pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(take && (mode || last)) - 2'(q_pop);
        end
    end

    // Queue payload; norm sums travel alongside their report command.
    always_ff @(posedge clk)
    begin
        if (take && (mode || last))
        begin
            q_reg[wp_reg] <= cmd;
            qw_reg[wp_reg] <= wsum_next;
            qg_reg[wp_reg] <= gsum_next;
        end
    end

    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd = q_reg[rp_reg];
    assign wsum_snap = qw_reg[rp_reg];
    assign gsum_snap = qg_reg[rp_reg];

endmodule

// ===== rtl/core/lars_back.sv =====
// ----------------------------------------------------------------------------
// LARS back part
// Runs the update arithmetic and the end-of-pass square roots, division and rate multiply.
// ----------------------------------------------------------------------------
module lars_back
    import lars_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  lars_cmd_t        q_cmd,
    input  logic [47:0]      wsum,
    input  logic [47:0]      gsum,
    output logic             q_pop,
    input  logic [23:0]      base_rate,
    input  logic [15:0]      momentum_coef,
    input  logic [23:0]      trust_ratio,
    input  logic [23:0]      decay_coef,
    input  logic             mask_enable,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             is_update,
    output logic signed [15:0] new_history,
    output logic [31:0]      lars_rate,
    output logic             end_mark
);

    // Ceiling of the Q.24 trust ratio.
    localparam logic [40:0] RatioMax = {1'b0, {40{1'b1}}};

    bk_state_t state_reg, state_next;
    lars_cmd_t cmd_reg;
    logic [31:0] rate_reg;
    logic        ov_reg;
    logic signed [15:0] nh_reg;
    logic        upd_reg, end_reg;
    logic signed [48:0] p1_reg, p2_reg;
    logic signed [15:0] hq_reg;
    // Iteration registers for the two square roots and the division.
    logic [61:0] wrem_reg, grem_reg;
    logic [30:0] wroot_reg, groot_reg;
    logic [6:0]  step_reg;
    logic [81:0] div_reg;
    logic [57:0] den_reg;
    logic [58:0] rem_reg;
    logic [40:0] quo_reg;
    logic        zero_reg;
    logic [63:0] rprod;
    logic signed [49:0] acc;
    logic signed [50:0] acc_r;
    logic signed [33:0] mprod;
    logic signed [34:0] mprod_r;
    logic signed [15:0] nh_sat, mk_sat;
    logic [61:0] wtrial, gtrial;
    logic        wfit, gfit;
    logic [30:0] wroot_nx, groot_nx;
    logic [58:0] rsh;
    logic [41:0] qsh;

    function automatic logic signed [15:0] sat16(input logic signed [50:0] v);
        logic signed [15:0] r;
        begin
            r = (v > 51'sd32767) ? 16'sh7fff : (v < -51'sd32768) ? 16'sh8000 : v[15:0];
            return r;
        end
    endfunction

    assign q_pop = q_valid && (state_reg == BK_IDLE) && !ov_reg;

    // Combinational arithmetic for the current step.
    always_comb
    begin
        acc = 50'(p1_reg) + 50'(p2_reg);
        acc_r = (51'(acc) + 51'sd8388608) >>> 24;
        nh_sat = sat16(acc_r);
        mprod = 34'(hq_reg) * 34'(cmd_reg.mask);
        mprod_r = (35'(mprod) + 35'sd2048) >>> 12;
        mk_sat = sat16(51'(mprod_r));
        // Trial value (root << (step + 1)) | (1 << 2*step) for the next root bit.
        wtrial = (62'(wroot_reg) << (step_reg + 7'd1)) | (62'd1 << {step_reg, 1'b0});
        gtrial = (62'(groot_reg) << (step_reg + 7'd1)) | (62'd1 << {step_reg, 1'b0});
        wfit = (wrem_reg >= wtrial);
        gfit = (grem_reg >= gtrial);
        wroot_nx = wfit ? (wroot_reg | (31'd1 << step_reg)) : wroot_reg;
        groot_nx = gfit ? (groot_reg | (31'd1 << step_reg)) : groot_reg;
        rsh = {rem_reg[57:0], div_reg[81]};
        qsh = {quo_reg, 1'b0};
        rprod = 64'(base_rate) * 64'(quo_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            ov_reg <= 1'b0;
            rate_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            if (state_reg == BK_OUT)
                ov_reg <= 1'b1;
            if (state_reg == BK_RATE)
                rate_reg <= zero_reg ? {base_rate, 8'b0} :
                            (|rprod[63:48] ? 32'hffffffff : rprod[47:16]);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:     if (q_pop) state_next = q_cmd.is_update ? BK_UPD_MUL : BK_SQRT;
            BK_UPD_MUL:  state_next = (mask_enable) ? BK_UPD_MASK : BK_OUT;
            BK_UPD_MASK: state_next = BK_OUT;
            BK_SQRT:     if (step_reg == 7'd0) state_next = BK_DIV;
            BK_DIV:      if (step_reg == 7'd0) state_next = BK_RATE;
            BK_RATE:     state_next = BK_OUT;
            BK_OUT:      state_next = BK_IDLE;
            default:     state_next = BK_IDLE;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                cmd_reg <= q_cmd;
                p1_reg <= 49'($signed({1'b0, rate_reg})) * 49'(q_cmd.gradient);
                p2_reg <= (49'($signed({1'b0, momentum_coef})) * 49'(q_cmd.history)) <<< 8;
                wrem_reg <= {wsum, 14'b0};
                grem_reg <= {gsum, 14'b0};
                wroot_reg <= '0;
                groot_reg <= '0;
                step_reg <= 7'd30;
                zero_reg <= (wsum == '0) || (gsum == '0);
            end
            BK_UPD_MUL:
            begin
                nh_reg <= nh_sat;
                hq_reg <= nh_sat;
            end
            BK_UPD_MASK:
                nh_reg <= mk_sat;
            BK_SQRT:
            begin
                // One result bit per cycle of each root.
                if (wfit)
                    wrem_reg <= wrem_reg - wtrial;
                if (gfit)
                    grem_reg <= grem_reg - gtrial;
                wroot_reg <= wroot_nx;
                groot_reg <= groot_nx;
                if (step_reg == 7'd0)
                begin
                    // Dividend is the numerator followed by 24 fraction bits.
                    div_reg <= {58'(trust_ratio) * 58'(wroot_nx), 24'b0};
                    den_reg <= {3'b0, groot_nx, 24'b0} + 58'(decay_coef) * 58'(wroot_nx);
                    rem_reg <= '0;
                    quo_reg <= '0;
                    step_reg <= 7'd81;
                end
                else
                    step_reg <= step_reg - 7'd1;
            end
            BK_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                if (rsh >= {1'b0, den_reg})
                begin
                    rem_reg <= rsh - {1'b0, den_reg};
                    quo_reg <= |qsh[41:40] ? RatioMax : qsh[40:0] | 41'd1;
                end
                else
                begin
                    rem_reg <= rsh;
                    quo_reg <= |qsh[41:40] ? RatioMax : qsh[40:0];
                end
                div_reg <= {div_reg[80:0], 1'b0};
                step_reg <= step_reg - 7'd1;
            end
            default: ;
        endcase
        if (state_reg == BK_OUT)
        begin
            upd_reg <= cmd_reg.is_update;
            end_reg <= cmd_reg.last;
            if (!cmd_reg.is_update)
                nh_reg <= '0;
        end
    end

    assign out_valid = ov_reg;
    assign is_update = upd_reg;
    assign new_history = nh_reg;
    assign lars_rate = rate_reg;
    assign end_mark = end_reg;

endmodule

// ===== rtl/core/lars_momentum_update_unit.sv =====
// ----------------------------------------------------------------------------
// LARS momentum update unit
// Norm accumulation pass and momentum update pass for one tensor.
// ----------------------------------------------------------------------------
// Norm-pass elements that are not last are absorbed in one cycle each by the
// front accumulator and give no result. Every other element is queued for the
// back part, which handles one command at a time; a two-entry queue lets the
// front keep accepting while the back is busy, and the input stalls once both
// entries are taken. An update element passes in the back part through the pop
// with the two products, rounding, masking when enabled, the output register
// and the result transfer, which the receiver can stall. The end of a norm
// pass runs the pop, 31 iterations of the paired square roots, 82 of the
// restoring divider, the rate multiply, the output register and the result
// transfer.
module lars_momentum_update_unit
    import lars_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             mode,
    input  logic signed [15:0] weight,
    input  logic signed [15:0] gradient,
    input  logic signed [15:0] history,
    input  logic signed [15:0] mask,
    input  logic             last,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             is_update,
    output logic signed [15:0] new_history,
    output logic [31:0]      lars_rate,
    output logic             end_mark
);

    logic [23:0] base_rate_reg, trust_reg, decay_reg;
    logic [15:0] mom_reg;
    logic        mask_en_reg;
    logic [47:0] wsum, gsum;
    logic        q_valid, q_pop;
    lars_cmd_t   q_cmd;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_rate_reg <= 24'd65536;
            mom_reg <= 16'd58982;
            trust_reg <= 24'd16777;
            decay_reg <= 24'd8389;
            mask_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BASE_RATE: base_rate_reg <= cfg_data;
                CFG_MOMENTUM:  mom_reg <= cfg_data[15:0];
                CFG_TRUST:     trust_reg <= cfg_data;
                CFG_DECAY:     decay_reg <= cfg_data;
                CFG_MASK_EN:   mask_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    lars_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .mode, .weight, .gradient,
        .history, .mask, .last, .wsum_snap(wsum), .gsum_snap(gsum),
        .q_valid, .q_cmd, .q_pop
    );

    lars_back u_back (
        .clk, .rst_n, .q_valid, .q_cmd, .wsum, .gsum, .q_pop,
        .base_rate(base_rate_reg), .momentum_coef(mom_reg),
        .trust_ratio(trust_reg), .decay_coef(decay_reg),
        .mask_enable(mask_en_reg), .out_valid, .out_stall, .is_update,
        .new_history, .lars_rate, .end_mark
    );

    // A result is held while stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(new_history))
        else $error("result dropped under stall");

    // Reports carry a cleared history field and the end mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_update |-> new_history == 16'sd0 && end_mark)
        else $error("bad rate report");

endmodule

// ===== tb/lars_momentum_update_unit_tb.sv =====
// ----------------------------------------------------------------------------
// LARS momentum update unit testbench
// Streams norm passes and update passes through the unit under random
// configurations, sender gaps and receiver stalls. A local predictor computes
// the rate reports and new history elements, and every output transfer is
// compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lars_momentum_update_unit_tb;
    import lars_pkg::*;

    localparam int        CYCLE_LIMIT = 600000;
    localparam int        SETTLE_CYCLES = 150;
    localparam int        RANDOM_ELEMENTS = 1600;
    localparam logic [63:0] SUM_MAX = (64'd1 << 48) - 64'd1;
    localparam logic [63:0] RATIO_MAX = (64'd1 << 40) - 64'd1;

    typedef struct {
        logic               mode;
        logic signed [15:0] weight;
        logic signed [15:0] gradient;
        logic signed [15:0] history;
        logic signed [15:0] mask;
        logic               last;
    } element_t;

    typedef struct {
        logic               is_update;
        logic signed [15:0] new_history;
        logic [31:0]        lars_rate;
        logic               end_mark;
    } update_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               mode = 1'b0;
    logic signed [15:0] weight = '0;
    logic signed [15:0] gradient = '0;
    logic signed [15:0] history = '0;
    logic signed [15:0] mask = '0;
    logic               last = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               is_update;
    logic signed [15:0] new_history;
    logic [31:0]        lars_rate;
    logic               end_mark;

    // Predictor copy of registers and state.
    logic [23:0] pr_base_rate;
    logic [15:0] pr_momentum;
    logic [23:0] pr_trust;
    logic [23:0] pr_decay;
    logic        pr_mask_en;
    logic [63:0] weight_sq_sum;
    logic [63:0] grad_sq_sum;
    logic [31:0] kept_rate;

    update_result_t expected_results[$];
    int errors = 0;
    int cycles = 0;
    int elements_sent = 0;
    int burst_left = 0;
    bit sender_gaps = 1'b0;
    int stall_level = 0;
    int hold_request = 0;
    int hold_seen = 0;
    int hold_cycles = 0;
    int hold_left = 0;

    lars_momentum_update_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .weight     (weight),
        .gradient   (gradient),
        .history    (history),
        .mask       (mask),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .is_update  (is_update),
        .new_history(new_history),
        .lars_rate  (lars_rate),
        .end_mark   (end_mark)
    );

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver stall pattern, with long hold-offs on request.
    always @(posedge clk)
    begin
        if (hold_request != hold_seen)
        begin
            hold_seen = hold_request;
            hold_left = hold_cycles;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (stall_level == 0)
            out_stall <= 1'b0;
        else if (stall_level == 1)
            out_stall <= ($urandom_range(0, 9) < 2);
        else
            out_stall <= ($urandom_range(0, 9) < 7);
    end

    // Output checker; outputs are stable at the falling edge before the transfer.
    always @(negedge clk)
    begin
        update_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result is_update=%0d new_history=%0d rate=%h",
                         $time, is_update, new_history, lars_rate);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (is_update !== exp_r.is_update)
                begin
                    $display("%0t: is_update expected %0d actual %0d", $time,
                             exp_r.is_update, is_update);
                    errors++;
                end
                if (new_history !== exp_r.new_history)
                begin
                    $display("%0t: new_history expected %0d actual %0d", $time,
                             exp_r.new_history, new_history);
                    errors++;
                end
                if (lars_rate !== exp_r.lars_rate)
                begin
                    $display("%0t: rate expected %h actual %h", $time,
                             exp_r.lars_rate, lars_rate);
                    errors++;
                end
                if (end_mark !== exp_r.end_mark)
                begin
                    $display("%0t: end_mark expected %0d actual %0d", $time,
                             exp_r.end_mark, end_mark);
                    errors++;
                end
            end
        end
    end

    // Floor square root of a 64-bit value below 2^62.
    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Quotient num * 2^24 / den, saturated at the ratio ceiling.
    function automatic logic [63:0] trust_quotient(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = num / den;
        r = num % den;
        if (q > RATIO_MAX)
            return RATIO_MAX;
        for (int i = 0; i < 24; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q = q | 64'd1;
            end
            if (q > RATIO_MAX)
                return RATIO_MAX;
        end
        return q;
    endfunction

    // Round half up after dropping s fraction bits, then clamp to Q4.12.
    function automatic longint round_clamp16(longint v, int s);
        longint t;
        longint f;
        t = v + (longint'(1) <<< (s - 1));
        f = t >>> s;
        if (f > 32767)
            return 32767;
        if (f < -32768)
            return -32768;
        return f;
    endfunction

    function automatic logic [31:0] layer_rate();
        logic [63:0] nw;
        logic [63:0] ng;
        logic [63:0] den;
        logic [63:0] ratio;
        logic [63:0] rate;
        if (weight_sq_sum == 0 || grad_sq_sum == 0)
            return {pr_base_rate, 8'd0};
        nw = floor_sqrt(weight_sq_sum << 14);
        ng = floor_sqrt(grad_sq_sum << 14);
        den = (ng << 24) + 64'(pr_decay) * nw;
        ratio = trust_quotient(64'(pr_trust) * nw, den);
        rate = (64'(pr_base_rate) * ratio) >> 16;
        return (rate > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rate[31:0];
    endfunction

    function automatic logic [63:0] add_square(logic [63:0] sum, logic signed [15:0] v);
        logic [63:0] s;
        s = sum + 64'(longint'(v) * longint'(v));
        return (s > SUM_MAX) ? SUM_MAX : s;
    endfunction

    // Advance the predictor by one accepted element and queue its result if it has one.
    task automatic predict_element(element_t e);
        update_result_t r;
        longint acc;
        longint nh;
        if (e.mode == 1'b0)
        begin
            weight_sq_sum = add_square(weight_sq_sum, e.weight);
            grad_sq_sum = add_square(grad_sq_sum, e.gradient);
            if (e.last)
            begin
                kept_rate = layer_rate();
                weight_sq_sum = '0;
                grad_sq_sum = '0;
                r.is_update = 1'b0;
                r.new_history = '0;
                r.lars_rate = kept_rate;
                r.end_mark = 1'b1;
                expected_results.push_back(r);
            end
        end
        else
        begin
            acc = longint'(kept_rate) * longint'(e.gradient)
                + longint'(pr_momentum) * longint'(e.history) * 256;
            nh = round_clamp16(acc, 24);
            if (pr_mask_en)
                nh = round_clamp16(nh * longint'(e.mask), 12);
            r.is_update = 1'b1;
            r.new_history = nh[15:0];
            r.lars_rate = kept_rate;
            r.end_mark = e.last;
            expected_results.push_back(r);
        end
    endtask

    // Offer one element and wait for its transfer; called and returns at a rising edge.
    task automatic send_element(element_t e);
        logic stalled;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (sender_gaps)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        mode <= e.mode;
        weight <= e.weight;
        gradient <= e.gradient;
        history <= e.history;
        mask <= e.mask;
        last <= e.last;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
        predict_element(e);
        elements_sent++;
    endtask

    function automatic logic signed [15:0] rand_value();
        logic signed [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return v >>> $urandom_range(0, 12);
        endcase
    endfunction

    function automatic element_t make_element(logic m, logic l);
        element_t e;
        e.mode = m;
        e.weight = rand_value();
        e.gradient = rand_value();
        e.history = rand_value();
        e.mask = rand_value();
        e.last = l;
        return e;
    endfunction

    function automatic element_t fixed_element(logic m, logic signed [15:0] w,
                                               logic signed [15:0] g,
                                               logic signed [15:0] h,
                                               logic signed [15:0] k, logic l);
        element_t e;
        e.mode = m;
        e.weight = w;
        e.gradient = g;
        e.history = h;
        e.mask = k;
        e.last = l;
        return e;
    endfunction

    // Wait until every expected result has arrived and the unit has settled.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all registers; only called while the unit is idle.
    task automatic write_config(logic [23:0] br, logic [15:0] mc, logic [23:0] tr,
                                logic [23:0] dc, logic me);
        cfg_we <= 1'b1;
        cfg_index <= CFG_BASE_RATE;
        cfg_data <= br;
        @(posedge clk);
        cfg_index <= CFG_MOMENTUM;
        cfg_data <= 24'(mc);
        @(posedge clk);
        cfg_index <= CFG_TRUST;
        cfg_data <= tr;
        @(posedge clk);
        cfg_index <= CFG_DECAY;
        cfg_data <= dc;
        @(posedge clk);
        cfg_index <= CFG_MASK_EN;
        cfg_data <= 24'(me);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        pr_base_rate = br;
        pr_momentum = mc;
        pr_trust = tr;
        pr_decay = dc;
        pr_mask_en = me;
    endtask

    task automatic random_config();
        logic [23:0] br;
        logic [15:0] mc;
        logic [23:0] tr;
        logic [23:0] dc;
        br = ($urandom_range(0, 5) == 0) ? 24'hFFFFFF : 24'($urandom) >> $urandom_range(0, 8);
        mc = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom);
        tr = ($urandom_range(0, 5) == 0) ? 24'hFFFFFF : 24'($urandom) >> $urandom_range(0, 10);
        dc = ($urandom_range(0, 5) == 0) ? 24'h000000 : 24'($urandom) >> $urandom_range(0, 12);
        write_config(br, mc, tr, dc, 1'($urandom));
    endtask

    // Updates before any norm pass see a zero rate, then extreme values in both passes.
    task automatic test_directed();
        send_element(fixed_element(1'b1, 0, 16'sh7FFF, 16'sh7FFF, 0, 1'b0));
        send_element(fixed_element(1'b1, 0, 16'sh8000, 16'sh8000, 0, 1'b1));
        send_element(fixed_element(1'b0, 16'sh8000, 16'sh8000, 0, 0, 1'b0));
        send_element(fixed_element(1'b0, 16'sh7FFF, 16'sh7FFF, 0, 0, 1'b1));
        send_element(fixed_element(1'b1, 0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0));
        send_element(fixed_element(1'b1, 0, 16'sh0001, 16'shFFFF, 0, 1'b1));
        // A zero weight norm falls back to the base rate.
        send_element(fixed_element(1'b0, 0, 16'sh1000, 0, 0, 1'b0));
        send_element(fixed_element(1'b0, 0, 16'sh8000, 0, 0, 1'b1));
        // A zero gradient norm does the same.
        send_element(fixed_element(1'b0, 16'sh1234, 0, 0, 0, 1'b1));
        // Single element norm pass, then modes interleaved inside a pass.
        send_element(fixed_element(1'b0, 16'sh0001, 16'sh0001, 0, 0, 1'b1));
        send_element(fixed_element(1'b0, 16'sh4000, 16'sh0100, 0, 0, 1'b0));
        send_element(fixed_element(1'b1, 16'sh7FFF, 16'sh2000, 16'sh1000, 0, 1'b0));
        send_element(fixed_element(1'b0, 16'shC000, 16'shFF00, 0, 0, 1'b1));
        send_element(fixed_element(1'b1, 0, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b1));
        drain();
    endtask

    // Extreme register settings, with and without masking.
    task automatic test_config_extremes();
        write_config(24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 24'h000000, 1'b1);
        for (int i = 0; i < 3; i++)
            send_element(make_element(1'b0, i == 2));
        send_element(fixed_element(1'b1, 0, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0));
        send_element(fixed_element(1'b1, 0, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b1));
        drain();
        write_config(24'h000000, 16'h0000, 24'h000000, 24'hFFFFFF, 1'b0);
        for (int i = 0; i < 3; i++)
            send_element(make_element(1'b0, i == 2));
        send_element(make_element(1'b1, 1'b1));
        drain();
        write_config(24'h000001, 16'h0001, 24'h000001, 24'h000001, 1'b1);
        send_element(fixed_element(1'b0, 16'sh0001, 16'sh7FFF, 0, 0, 1'b1));
        send_element(fixed_element(1'b1, 0, 16'sh7FFF, 16'sh0001, 16'sh0001, 1'b1));
        drain();
    endtask

    // Long receiver hold-off while the sender keeps offering update elements, then a norm pass.
    task automatic test_backpressure();
        sender_gaps = 1'b0;
        stall_level = 0;
        hold_cycles = 400;
        hold_request++;
        for (int i = 0; i < 40; i++)
            send_element(make_element(1'b1, i == 39));
        for (int i = 0; i < 8; i++)
            send_element(make_element(1'b0, i == 7));
        drain();
    endtask

    // Well-formed tensors with random content, plus mixed-mode noise.
    task automatic test_random_tensors();
        int n;
        while (elements_sent < RANDOM_ELEMENTS)
        begin
            sender_gaps = ($urandom_range(0, 2) != 0);
            stall_level = $urandom_range(0, 2);
            if ($urandom_range(0, 4) == 0)
            begin
                drain();
                random_config();
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
            for (int i = 0; i < n; i++)
                send_element(make_element(1'b0, i == n - 1));
            n = $urandom_range(1, 30);
            for (int i = 0; i < n; i++)
                send_element(make_element(1'b1, i == n - 1));
            if ($urandom_range(0, 5) == 0)
                for (int i = 0; i < 8; i++)
                    send_element(make_element(1'($urandom), 1'($urandom)));
        end
        drain();
    endtask

    initial
    begin
        pr_base_rate = 24'd65536;
        pr_momentum = 16'd58982;
        pr_trust = 24'd16777;
        pr_decay = 24'd8389;
        pr_mask_en = 1'b0;
        weight_sq_sum = '0;
        grad_sq_sum = '0;
        kept_rate = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random_tensors();
        if (errors == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/lars_pkg.sv
rtl/core/lars_front.sv
rtl/core/lars_back.sv
rtl/core/lars_momentum_update_unit.sv
tb/lars_momentum_update_unit_tb.sv
